// File: rtl/core/sle_pkg.sv
// Shared types, sizes and codes for the sequential list engine.
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_LOCATE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] item_value;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [WORD_W-1:0] read_value;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_length_out;
    } rsp_beat_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic              cmp_en;
        logic [IDX_W-1:0]  slot;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] key;
    } cell_cmd_t;

endpackage

// File: rtl/core/sle_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares with the key.
module sle_cell (
    input  logic                        clk,
    input  logic [sle_pkg::IDX_W-1:0]   idx,
    input  sle_pkg::cell_cmd_t          cmd,
    input  logic [sle_pkg::WORD_W-1:0]  left_data,
    input  logic [sle_pkg::WORD_W-1:0]  right_data,
    output logic [sle_pkg::WORD_W-1:0]  data,
    output logic                        match
);
    import sle_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              match_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins_en)
        begin
            if (idx == cmd.slot)
                data_next = cmd.key;
            else if (idx > cmd.slot)
                data_next = left_data;
        end
        else if (cmd.del_en && idx >= cmd.slot)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        // match is held until the next locate so a stalled response still sees it
        if (cmd.cmp_en)
            match_reg <= (LEN_W'(idx) < cmd.len) && (data_reg == cmd.key);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// File: rtl/core/sle_first_match.sv
// Priority encoder: 1-based position of the lowest set match flag, 0 if none.
module sle_first_match (
    input  logic [sle_pkg::CAPACITY-1:0] match_vec,
    output logic                         hit,
    output logic [sle_pkg::POS_W-1:0]    first_pos
);
    import sle_pkg::*;

    always_comb
    begin
        first_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                first_pos = POS_W'(i + 1);
        end
    end

    assign hit = |match_vec;

endmodule

// File: rtl/core/sequential_list_engine.sv
// Top level of the sequential list engine: sequencer, row of cells, response register.
//
// Ordered list of signed 32-bit words, CAPACITY entries, held in a row of cells.
// Request channel (req_valid / req_stall / req_data): one beat carries op, position
// and item_value. A beat is taken when req_valid is high and req_stall is low.
// Ops: get, locate, insert (later entries move up), delete (later entries move down).
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per request,
// with status, read_value, found_position and list_length_out.
//
// Timing: a request passes through the idle, execute and finish steps. The idle step
// registers the request, the execute step updates all cells at once (parallel shift,
// parallel compare), the finish step encodes the first matching cell and loads the
// response register. No new request is taken until the response register is loaded
// and the sequencer is back in its idle step.
//
// Reset clears the list length, the sequencer and the response valid; entry
// contents are left as they are and are never read before being written.
// A stalled response holds its beat; the sequencer waits in its final step until
// the response register is free, and takes no request meanwhile.
module sequential_list_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sle_pkg::req_beat_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sle_pkg::rsp_beat_t rsp_data
);
    import sle_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    req_beat_t         cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;

    // results staged between execute and finish
    logic [1:0]        res_status_reg;
    logic [WORD_W-1:0] res_read_reg;
    logic              res_locate_reg;

    logic              rsp_valid_reg;
    rsp_beat_t         rsp_data_reg;

    cell_cmd_t         cell_cmd;
    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic              hit;
    logic [POS_W-1:0]  first_pos;

    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  len_w;
    logic [POS_W-1:0]  pos_m1;
    logic [IDX_W-1:0]  slot;
    logic              pos_nz;
    logic              rd_ok;
    logic              ins_ok;
    logic              full;
    logic              in_exec;
    logic              rsp_free;
    logic [1:0]        exec_status;
    logic [WORD_W-1:0] exec_read;

    // ---------------- position checks against the current length
    assign pos_w   = CMP_W'(cmd_reg.position);
    assign len_w   = CMP_W'(len_reg);
    assign pos_m1  = cmd_reg.position - POS_W'(1);
    assign slot    = IDX_W'(pos_m1);
    assign pos_nz  = (cmd_reg.position != '0);
    assign rd_ok   = pos_nz && (pos_w <= len_w);
    assign ins_ok  = pos_nz && (pos_w <= len_w + CMP_W'(1));
    assign full    = (len_reg == LEN_W'(CAPACITY));
    assign in_exec = (state_reg == S_EXEC);

    always_comb
    begin
        cell_cmd.ins_en = 1'b0;
        cell_cmd.del_en = 1'b0;
        cell_cmd.cmp_en = 1'b0;
        cell_cmd.slot   = slot;
        cell_cmd.len    = len_reg;
        cell_cmd.key    = cmd_reg.item_value;
        exec_status     = ST_OK;
        exec_read       = '0;
        len_next        = len_reg;
        unique case (cmd_reg.op)
            OP_GET:
            begin
                if (rd_ok)
                    exec_read = cell_data[slot];
                else
                    exec_status = ST_BADPOS;
            end
            OP_LOCATE:
            begin
                // status settled in the finish step from the match flags
                cell_cmd.cmp_en = in_exec;
            end
            OP_INSERT:
            begin
                if (!ins_ok)
                    exec_status = ST_BADPOS;
                else if (full)
                    exec_status = ST_FULL;
                else
                begin
                    cell_cmd.ins_en = in_exec;
                    len_next        = len_reg + LEN_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (rd_ok)
                begin
                    exec_read       = cell_data[slot];
                    cell_cmd.del_en = in_exec;
                    len_next        = len_reg - LEN_W'(1);
                end
                else
                    exec_status = ST_BADPOS;
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // ---------------- row of cells, neighbors wired in a chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_d;
        logic [WORD_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cmd_reg.item_value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        sle_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .cmd        (cell_cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    sle_first_match u_first_match (
        .match_vec (match_vec),
        .hit       (hit),
        .first_pos (first_pos)
    );

    // ---------------- sequencer
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_exec)
                len_reg <= len_next;
            if (state_reg == S_FIN && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
            cmd_reg <= req_data;
        if (in_exec)
        begin
            res_status_reg <= exec_status;
            res_read_reg   <= exec_read;
            res_locate_reg <= (cmd_reg.op == OP_LOCATE);
        end
        if (state_reg == S_FIN && rsp_free)
        begin
            rsp_data_reg.read_value      <= res_read_reg;
            rsp_data_reg.list_length_out <= POS_W'(len_reg);
            if (res_locate_reg)
            begin
                rsp_data_reg.status         <= hit ? ST_OK : ST_NOTFOUND;
                rsp_data_reg.found_position <= first_pos;
            end
            else
            begin
                rsp_data_reg.status         <= res_status_reg;
                rsp_data_reg.found_position <= '0;
            end
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// File: test/sequential_list_engine_tb.sv
// Self-checking testbench for the sequential list engine.
`timescale 1ns / 100ps

module sequential_list_engine_tb;

    import sle_pkg::*;

    // Random part of the stimulus, after the directed opening.
    localparam int RANDOM_BEATS   = 1030;
    // Final stretch of beats (on either side) with no idling at all.
    localparam int CALM_TAIL      = 100;
    // Long receiver hold-off: where it starts and how long it lasts.
    localparam int BACKLOG_AT     = 300;
    localparam int BACKLOG_CYCLES = 40;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT    = 1000;
    // Settling time after the last response.
    localparam int DRAIN_CYCLES   = 8;

    // Software image of the list: the entries and the current length.
    typedef struct packed {
        logic [CAPACITY-1:0][WORD_W-1:0] slot;
        logic [LEN_W-1:0]                len;
    } list_image_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req_data  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp_data;

    req_beat_t   pending_q[$];   // requests waiting to be driven
    rsp_beat_t   answers_q[$];   // responses owed by the block, oldest first
    list_image_t plan_image;     // list as the stimulus generator sees it
    list_image_t model_image;    // list as updated by accepted request beats
    int          total_beats     = 0;
    int          beats_sent      = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          gap_left        = 0;
    int          hold_left       = 0;
    bit          backlog_done    = 1'b0;
    int          quiet_cycles    = 0;

    sequential_list_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one request to a list image and returns the response it owes.
    // Position checks come first; insert at length+1 appends; locate returns
    // the first match only.
    function automatic rsp_beat_t apply_request(inout list_image_t img,
                                                input req_beat_t rq);
        rsp_beat_t r;
        int        len;
        int        p;
        int        j;
        r   = '0;
        len = img.len;
        p   = rq.position;
        case (rq.op)
            OP_GET:
            begin
                if (p < 1 || p > len)
                    r.status = ST_BADPOS;
                else
                    r.read_value = img.slot[p-1];
            end
            OP_LOCATE:
            begin
                r.status = ST_NOTFOUND;
                for (j = 0; j < len; j++)
                begin
                    if (r.status == ST_NOTFOUND && img.slot[j] == rq.item_value)
                    begin
                        r.status         = ST_OK;
                        r.found_position = POS_W'(j + 1);
                    end
                end
            end
            OP_INSERT:
            begin
                if (p < 1 || p > len + 1)
                    r.status = ST_BADPOS;
                else if (len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (j = len; j > p - 1; j--)
                        img.slot[j] = img.slot[j-1];
                    img.slot[p-1] = rq.item_value;
                    len++;
                end
            end
            OP_DELETE:
            begin
                if (p < 1 || p > len)
                    r.status = ST_BADPOS;
                else
                begin
                    r.read_value = img.slot[p-1];
                    for (j = p; j < len; j++)
                        img.slot[j-1] = img.slot[j];
                    len--;
                end
            end
        endcase
        img.len           = LEN_W'(len);
        r.list_length_out = POS_W'(len);
        return r;
    endfunction

    // Queues a request and tracks its effect so later picks can aim at live entries.
    task automatic plan_request(input logic [1:0] op, input int pos,
                                input logic [WORD_W-1:0] val);
        req_beat_t rq;
        rq.op         = op;
        rq.position   = POS_W'(pos);
        rq.item_value = val;
        pending_q.push_back(rq);
        void'(apply_request(plan_image, rq));
    endtask

    // Small values give duplicates (first-match checks), extremes hit the sign edges.
    function automatic logic [WORD_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return WORD_W'($urandom_range(0, 7));
        else if (roll < 35)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task report_mismatch(input string what, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
        $display("mismatch on response %0d: %s got %h want %h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int          roll;
        int          len;
        int          pos;
        logic [1:0]  op;
        logic [31:0] val;
        bit          filling;

        plan_image = '0;
        model_image = '0;

        // Directed opening: empty-list errors, a short list built with extremes, duplicates
        // and an append, searches and reads on it, then middle and edge deletes.
        plan_request(OP_GET,    1, 32'd0);
        plan_request(OP_DELETE, 1, 32'd0);
        plan_request(OP_LOCATE, 0, 32'd0);           // empty list: not found
        plan_request(OP_INSERT, 0, 32'd1);           // position zero
        plan_request(OP_INSERT, 2, 32'd1);           // beyond length+1
        plan_request(OP_INSERT, 1, 32'h8000_0000);
        plan_request(OP_INSERT, 2, 32'h7fff_ffff);   // append
        plan_request(OP_INSERT, 1, 32'hffff_ffff);   // at the head
        plan_request(OP_INSERT, 2, 32'h0000_0000);   // in the middle
        plan_request(OP_INSERT, 5, 32'h0000_0000);   // duplicate at the tail
        plan_request(OP_LOCATE, 16, 32'h0000_0000);  // first of two matches
        plan_request(OP_LOCATE, 0, 32'h7fff_ffff);
        plan_request(OP_LOCATE, 0, 32'd12345);       // no match
        plan_request(OP_GET,    5, 32'd0);           // last entry
        plan_request(OP_GET,    6, 32'd0);
        plan_request(OP_GET,    0, 32'd0);
        plan_request(OP_DELETE, 0, 32'd0);
        plan_request(OP_DELETE, 6, 32'd0);
        plan_request(OP_DELETE, 3, 32'd0);           // middle
        plan_request(OP_DELETE, 4, 32'd0);           // last
        plan_request(OP_DELETE, 1, 32'd0);           // first
        plan_request(OP_INSERT, 4, 32'd9);           // length+2
        plan_request(OP_GET,    2, 32'd0);

        // Random part: fill and drain the list in turns with random content so
        // that full, empty and everything between are visited many times.
        filling = 1'b1;
        repeat (RANDOM_BEATS)
        begin
            len = plan_image.len;
            if (len == 0)
                filling = 1'b1;
            else if (len == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if ($urandom_range(0, 99) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            val  = pick_value();
            if (roll < 6)
                op = 2'($urandom_range(0, 3));
            else if (roll < 56)
                op = filling ? OP_INSERT : OP_DELETE;
            else if (roll < 66)
                op = filling ? OP_DELETE : OP_INSERT;
            else if (roll < 83)
                op = OP_GET;
            else
                op = OP_LOCATE;

            if (roll < 6 || op == OP_LOCATE)
                pos = $urandom_range(0, 16);
            else if (op == OP_INSERT)
                pos = $urandom_range(1, (len + 1 > 16) ? 16 : len + 1);
            else
                pos = (len > 0) ? $urandom_range(1, len) : $urandom_range(0, 1);

            // Most searches look for a value that is really in the list.
            if (op == OP_LOCATE && len > 0 && $urandom_range(0, 9) < 6)
                val = plan_image.slot[$urandom_range(0, len - 1)];
            plan_request(op, pos, val);
        end
        total_beats = pending_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (beats_sent < total_beats || answers_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Request driver. Records the expected response for every accepted beat,
    // then offers the next one unless a random gap is running. Gaps only
    // start in alternate windows of 64 beats, and never in the tail.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                answers_q.push_back(apply_request(model_image, req_data));
                beats_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                    req_valid <= 1'b0;
                else if (beats_sent < total_beats - CALM_TAIL
                         && ((beats_sent >> 6) & 1) == 0
                         && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 3) - 1;
                    req_valid <= 1'b0;
                end
                else
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_q.pop_front();
                end
            end
        end
    end

    // Response monitor. Checks each accepted beat against the oldest
    // expectation, then decides the stall for the next cycle: one long
    // hold-off that backs the block up into its request side, plus short
    // random bursts in windows offset from the driver's.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_q.size() == 0)
                    report_mismatch("beat with nothing pending", rsp_data.read_value, '0);
                else
                begin
                    want = answers_q.pop_front();
                    if (rsp_data.status !== want.status)
                        report_mismatch("status", WORD_W'(rsp_data.status),
                                        WORD_W'(want.status));
                    if (rsp_data.read_value !== want.read_value)
                        report_mismatch("read_value", rsp_data.read_value,
                                        want.read_value);
                    if (rsp_data.found_position !== want.found_position)
                        report_mismatch("found_position",
                                        WORD_W'(rsp_data.found_position),
                                        WORD_W'(want.found_position));
                    if (rsp_data.list_length_out !== want.list_length_out)
                        report_mismatch("list_length_out",
                                        WORD_W'(rsp_data.list_length_out),
                                        WORD_W'(want.list_length_out));
                end
                results_checked++;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!backlog_done && results_checked >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                hold_left    = BACKLOG_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (results_checked < total_beats - CALM_TAIL
                     && ((results_checked >> 6) & 1) == 1
                     && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 3) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Hang detector: any beat on either channel resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

endmodule
